// ===== rtl/core/tpf_pkg.sv =====
// Shared types, constants and register indexes for the TCP port filter with payload capture.
// Used by every module under rtl/core; depends on nothing else.
package tpf_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;

    // Byte positions of the fixed header fields within the frame.
    localparam logic [15:0] POS_ETYPE_HI   = 16'd12;
    localparam logic [15:0] POS_ETYPE_LO   = 16'd13;
    localparam logic [15:0] POS_IHL        = 16'd14;
    localparam logic [15:0] POS_TOTAL_HI   = 16'd16;
    localparam logic [15:0] POS_TOTAL_LO   = 16'd17;
    localparam logic [15:0] POS_PROTO      = 16'd23;
    localparam logic [15:0] POS_SRC_ADDR   = 16'd26;
    localparam logic [15:0] POS_DST_ADDR   = 16'd30;
    localparam logic [15:0] POS_SATURATED  = 16'hFFFF;

    // Offsets inside the TCP header.
    localparam logic [15:0] TCP_DPORT_OFS  = 16'd2;
    localparam logic [15:0] TCP_SEQ_OFS    = 16'd4;
    localparam logic [15:0] TCP_ACK_OFS    = 16'd8;
    localparam logic [15:0] TCP_DOFF_OFS   = 16'd12;
    localparam logic [15:0] TYPE_BYTE_OFS  = 16'd3;
    localparam logic signed [17:0] MIN_PAYLOAD = 18'sd4;

    // Capture buffer size; the per-frame limit is clamped to one less than this.
    localparam int CAPTURE_BYTES = 400;
    localparam int CAP_MAX_INT   = (CAPTURE_BYTES - 1 > 511) ? 511 : CAPTURE_BYTES - 1;
    localparam logic [8:0] CAP_MAX = 9'(CAP_MAX_INT);

    localparam logic [15:0] PORT_A_RESET   = 16'd50051;
    localparam logic [15:0] PORT_B_RESET   = 16'd50052;
    localparam logic [15:0] PORT_C_RESET   = 16'd50053;
    localparam logic [8:0]  CAP_LIMIT_RESET = 9'd399;

    localparam int OUT_FIFO_DEPTH = 4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        CFG_PORT_A    = 2'd0,
        CFG_PORT_B    = 2'd1,
        CFG_PORT_C    = 2'd2,
        CFG_CAP_LIMIT = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] port_a;
        logic [15:0] port_b;
        logic [15:0] port_c;
        logic [8:0]  capture_limit;
    } t_cfg;

    // Per-frame parse state, cleared after each last byte.
    typedef struct packed {
        logic [15:0] byte_offset;
        logic [15:0] ether_type;
        logic [3:0]  ip_header_words;
        logic [7:0]  ip_protocol;
        logic [15:0] ip_total_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] tcp_sport;
        logic [15:0] tcp_dport;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [3:0]  tcp_header_words;
        logic [7:0]  type_byte;
        logic [8:0]  captured_count;
    } t_frame;

    typedef struct packed {
        logic        record_kind;
        logic [7:0]  payload_byte;
        logic        accepted;
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] tcp_sport;
        logic [15:0] tcp_dport;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [7:0]  message_type;
        logic [15:0] payload_length;
        logic        end_of_frame;
    } t_record;

    // Up to two records per input word; the second is only used when the first is.
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_record r0;
        t_record r1;
    } t_push;

endpackage

// ===== rtl/core/tpf_cfg_regs.sv =====
// Configuration register bank: selecting ports and the capture limit.
// Depends on tpf_pkg.
module tpf_cfg_regs
    import tpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [1:0]  i_index,
    input  logic [15:0] i_data,
    output logic        o_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            case (t_cfg_index'(i_index))
                CFG_PORT_A:    n_cfg.port_a        = i_data;
                CFG_PORT_B:    n_cfg.port_b        = i_data;
                CFG_PORT_C:    n_cfg.port_c        = i_data;
                CFG_CAP_LIMIT: n_cfg.capture_limit = i_data[8:0];
                default:       n_cfg               = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.port_a        <= PORT_A_RESET;
            r_cfg.port_b        <= PORT_B_RESET;
            r_cfg.port_c        <= PORT_C_RESET;
            r_cfg.capture_limit <= CAP_LIMIT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== rtl/core/tpf_parser.sv =====
// Header parser, frame filter and payload capture decision, one frame byte per accepted word.
// Depends on tpf_pkg; produces up to two records per word for the output queue.
module tpf_parser
    import tpf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_cfg       i_cfg,
    output t_push      o_push
);

    t_frame r_frame;
    t_frame n_frame;
    t_frame upd;

    logic [15:0]        pos;
    logic [15:0]        tcp_start;
    logic [15:0]        pay_start;
    logic [15:0]        rel;
    logic [16:0]        pay_end;
    logic signed [17:0] plen;
    logic [8:0]         cap_lim;
    logic               early;
    logic               emit;
    logic               fit;
    t_record            pay_rec;
    t_record            sum_rec;

    always_comb begin
        pos = r_frame.byte_offset;
        upd = r_frame;

        // Fixed-position Ethernet and IPv4 fields.
        if (pos == POS_ETYPE_HI) begin
            upd.ether_type = {i_byte, 8'd0};
        end else if (pos == POS_ETYPE_LO) begin
            upd.ether_type[7:0] = i_byte;
        end else if (pos == POS_IHL) begin
            upd.ip_header_words = i_byte[3:0];
        end else if (pos == POS_TOTAL_HI) begin
            upd.ip_total_length = {i_byte, 8'd0};
        end else if (pos == POS_TOTAL_LO) begin
            upd.ip_total_length[7:0] = i_byte;
        end else if (pos == POS_PROTO) begin
            upd.ip_protocol = i_byte;
        end else if (pos >= POS_SRC_ADDR && pos < POS_DST_ADDR) begin
            upd.src_addr[{2'(pos - POS_SRC_ADDR), 3'd0} +: 8] = i_byte;
        end else if (pos >= POS_DST_ADDR && pos < POS_DST_ADDR + 16'd4) begin
            upd.dst_addr[{2'(pos - POS_DST_ADDR), 3'd0} +: 8] = i_byte;
        end

        // TCP header, placed by the IP header length.
        tcp_start = ETH_HDR_LEN + {10'd0, upd.ip_header_words, 2'b00};
        rel       = pos - tcp_start;
        if (upd.ip_header_words >= MIN_HDR_WORDS && pos >= tcp_start) begin
            if (rel < TCP_DPORT_OFS) begin
                upd.tcp_sport = {upd.tcp_sport[7:0], i_byte};
            end else if (rel < TCP_SEQ_OFS) begin
                upd.tcp_dport = {upd.tcp_dport[7:0], i_byte};
            end else if (rel < TCP_ACK_OFS) begin
                upd.seq_number = {upd.seq_number[23:0], i_byte};
            end else if (rel < TCP_DOFF_OFS) begin
                upd.ack_number = {upd.ack_number[23:0], i_byte};
            end else if (rel == TCP_DOFF_OFS) begin
                upd.tcp_header_words = i_byte[7:4];
            end
        end

        pay_start = tcp_start + {10'd0, upd.tcp_header_words, 2'b00};
        plen = $signed({2'b00, upd.ip_total_length})
             - $signed({12'd0, upd.ip_header_words, 2'b00})
             - $signed({12'd0, upd.tcp_header_words, 2'b00});
        // Payload start plus payload length collapses to the Ethernet header plus total length.
        pay_end = {1'b0, upd.ip_total_length} + {1'b0, ETH_HDR_LEN};

        early = (upd.ether_type == ETHERTYPE_IPV4) && (upd.ip_protocol == PROTO_TCP)
             && (upd.ip_header_words >= MIN_HDR_WORDS)
             && (upd.tcp_header_words >= MIN_HDR_WORDS)
             && (upd.tcp_sport == i_cfg.port_a || upd.tcp_sport == i_cfg.port_b
                 || upd.tcp_sport == i_cfg.port_c || upd.tcp_dport == i_cfg.port_a
                 || upd.tcp_dport == i_cfg.port_b || upd.tcp_dport == i_cfg.port_c)
             && (plen >= MIN_PAYLOAD);

        cap_lim = (i_cfg.capture_limit > CAP_MAX) ? CAP_MAX : i_cfg.capture_limit;

        emit = 1'b0;
        if (upd.ip_header_words >= MIN_HDR_WORDS && upd.tcp_header_words >= MIN_HDR_WORDS
            && pos >= pay_start) begin
            if (pos - pay_start == TYPE_BYTE_OFS) begin
                upd.type_byte = i_byte;
            end
            emit = early && ({1'b0, pos} < pay_end)
                && (upd.captured_count < cap_lim);
            if (emit) begin
                upd.captured_count = upd.captured_count + 9'd1;
            end
        end

        fit = pay_end <= ({1'b0, pos} + 17'd1);

        pay_rec              = '0;
        pay_rec.record_kind  = KIND_PAYLOAD;
        pay_rec.payload_byte = i_byte;

        sum_rec                = '0;
        sum_rec.record_kind    = KIND_SUMMARY;
        sum_rec.accepted       = early && fit;
        sum_rec.src_address    = upd.src_addr;
        sum_rec.dst_address    = upd.dst_addr;
        sum_rec.tcp_sport      = upd.tcp_sport;
        sum_rec.tcp_dport      = upd.tcp_dport;
        sum_rec.seq_number     = upd.seq_number;
        sum_rec.ack_number     = upd.ack_number;
        sum_rec.message_type   = upd.type_byte;
        sum_rec.payload_length = (plen > 18'sd0) ? plen[15:0] : 16'd0;
        sum_rec.end_of_frame   = 1'b1;

        o_push.v0 = i_accept && (emit || i_last);
        o_push.v1 = i_accept && emit && i_last;
        o_push.r0 = emit ? pay_rec : sum_rec;
        o_push.r1 = sum_rec;

        if (i_last) begin
            n_frame = '0;
        end else begin
            n_frame = upd;
            if (pos != POS_SATURATED) begin
                n_frame.byte_offset = pos + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
        end else if (i_accept) begin
            r_frame <= n_frame;
        end
    end

`ifndef SYNTHESIS
    a_offset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last) |=> (r_frame.byte_offset == 16'd0))
        else $error("byte offset not cleared after last byte");

    a_capture_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame.captured_count <= CAP_MAX)
        else $error("captured count above capture limit");
`endif

endmodule

// ===== rtl/core/tpf_out_fifo.sv =====
// Small result queue that takes up to two records per cycle and hands out one.
// Depends on tpf_pkg; decouples the parser from output backpressure.
module tpf_out_fifo
    import tpf_pkg::*;
#(
    parameter int DEPTH = OUT_FIFO_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output logic    o_room2,
    output logic    o_valid,
    output t_record o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM2_MAX = CNT_W'(DEPTH - 2);

    t_record          r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W-1:0] wr1;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign o_room2 = (r_count <= ROOM2_MAX);
    assign pop     = o_valid && i_pop;
    assign wr1     = ptr_inc(r_wr);

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.v0) begin
            n_wr = i_push.v1 ? ptr_inc(wr1) : wr1;
        end
        if (pop) begin
            n_rd = ptr_inc(r_rd);
        end
        n_count = r_count + CNT_W'(i_push.v0) + CNT_W'(i_push.v1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[wr1] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> (r_count <= ROOM2_MAX))
        else $error("record pushed without room for two");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v1 |-> (i_push.v0 && i_push.r1.end_of_frame))
        else $error("second record pushed without first or not a summary");
`endif

endmodule

// ===== rtl/core/tcp_port_filter_payload_capture.sv =====
// Top level of the TCP port filter with payload capture: configuration bank, parser, result queue.
// Depends on tpf_pkg, tpf_cfg_regs, tpf_parser and tpf_out_fifo.
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ------------------------------------------
//  s (in)    input      i_s_tvalid / o_s_tready   frame_byte in tdata, frame_last in tlast
//  m (out)   output     o_m_tvalid / i_m_tready   record fields in tdata, kind in tuser,
//                                                 end_of_frame in tlast
//  cfg       input      i_cfg_valid / o_cfg_ready register index and 16-bit write data
//
// One frame byte is taken per cycle while the queue has room for two records; each word is
// parsed in the cycle it is accepted and its records land in the result queue at that edge,
// behind any records it already holds. A last byte that also carries payload produces two
// records; the queue absorbs them while output drains at one record per cycle under i_m_tready.
// Reset is synchronous and active low; it clears the parse state and the queue and loads the
// default ports (50051, 50052, 50053) and capture limit (399).
// o_s_tready drops only while the queue lacks room for two records, i.e. under output stalls.
module tcp_port_filter_payload_capture
    import tpf_pkg::*;
#(
    parameter int FIFO_DEPTH = OUT_FIFO_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream. tdata: frame_byte[7:0].
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,
    input  logic         i_s_tlast,
    // Output stream. tdata from bit 0 up: payload_byte[7:0], accepted[8], src_address[40:9],
    // dst_address[72:41], TCP source port[88:73], TCP destination port[104:89],
    // seq_number[136:105], ack_number[168:137], message_type[176:169],
    // payload_length[192:177], zeros[199:193].
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [199:0] o_m_tdata,
    // tuser: record_kind[0] (0 payload word, 1 frame summary).
    output logic         o_m_tuser,
    output logic         o_m_tlast,
    // Configuration write channel.
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);

    t_cfg    cfg;
    t_push   push;
    t_record head;
    logic    room2;
    logic    s_accept;

    // A byte is taken only when the queue can hold both records it might produce.
    assign o_s_tready = room2;
    assign s_accept   = i_s_tvalid && room2;

    tpf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    tpf_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_cfg    (cfg),
        .o_push   (push)
    );

    tpf_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_m_tready),
        .o_room2 (room2),
        .o_valid (o_m_tvalid),
        .o_head  (head)
    );

    // Pack the head record onto the output stream.
    assign o_m_tdata = {7'd0, head.payload_length, head.message_type, head.ack_number,
                        head.seq_number, head.tcp_dport, head.tcp_sport, head.dst_address,
                        head.src_address, head.accepted, head.payload_byte};
    assign o_m_tuser = head.record_kind;
    assign o_m_tlast = head.end_of_frame;

endmodule

// ===== tb/tpf_record_checker.sv =====
`timescale 1ns / 100ps
// Record checker for the TCP port filter: predicts the record stream from the accepted frame bytes.
// Depends on tpf_pkg only; it watches the input, output and configuration channels from outside.
module tpf_record_checker
    import tpf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,
    input  logic         i_s_tlast,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [199:0] i_m_tdata,
    input  logic         i_m_tuser,
    input  logic         i_m_tlast,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_records_checked,
    output int           o_frames_accepted
);

    localparam int MAX_REPORTS = 10;

    t_cfg    cfg_shadow;
    t_frame  frame_st;
    t_record expected_records [$];
    int      fail_count;
    int      records_checked;
    int      frames_accepted;

    assign o_fail_count      = fail_count;
    assign o_records_checked = records_checked;
    assign o_frames_accepted = frames_accepted;

    function automatic int payload_len_now();
        return int'(frame_st.ip_total_length) - 4 * int'(frame_st.ip_header_words)
               - 4 * int'(frame_st.tcp_header_words);
    endfunction

    function automatic bit port_selected(logic [15:0] port);
        return port == cfg_shadow.port_a || port == cfg_shadow.port_b ||
               port == cfg_shadow.port_c;
    endfunction

    // Every check that can be settled before the frame ends.
    function automatic bit header_checks_pass();
        return frame_st.ether_type == ETHERTYPE_IPV4 && frame_st.ip_protocol == PROTO_TCP &&
               frame_st.ip_header_words >= MIN_HDR_WORDS &&
               frame_st.tcp_header_words >= MIN_HDR_WORDS &&
               (port_selected(frame_st.tcp_sport) || port_selected(frame_st.tcp_dport)) &&
               payload_len_now() >= MIN_PAYLOAD;
    endfunction

    function automatic string format_record(t_record r);
        return $sformatf("kind=%0d byte=%02h acc=%0d src=%08h dst=%08h sport=%0d dport=%0d %s",
                         r.record_kind, r.payload_byte, r.accepted, r.src_address,
                         r.dst_address, r.tcp_sport, r.tcp_dport,
                         $sformatf("seq=%08h ack=%08h type=%02h len=%0d eof=%0d",
                                   r.seq_number, r.ack_number, r.message_type,
                                   r.payload_length, r.end_of_frame));
    endfunction

    function automatic string differing_fields(t_record want, t_record got);
        string s;
        s = "";
        if (want.record_kind    != got.record_kind)    s = {s, " record_kind"};
        if (want.payload_byte   != got.payload_byte)   s = {s, " payload_byte"};
        if (want.accepted       != got.accepted)       s = {s, " accepted"};
        if (want.src_address    != got.src_address)    s = {s, " src_address"};
        if (want.dst_address    != got.dst_address)    s = {s, " dst_address"};
        if (want.tcp_sport      != got.tcp_sport)      s = {s, " tcp_sport"};
        if (want.tcp_dport      != got.tcp_dport)      s = {s, " tcp_dport"};
        if (want.seq_number     != got.seq_number)     s = {s, " seq_number"};
        if (want.ack_number     != got.ack_number)     s = {s, " ack_number"};
        if (want.message_type   != got.message_type)   s = {s, " message_type"};
        if (want.payload_length != got.payload_length) s = {s, " payload_length"};
        if (want.end_of_frame   != got.end_of_frame)   s = {s, " end_of_frame"};
        return s;
    endfunction

    // Advances the parse state by one frame byte and queues the records it causes.
    task automatic parse_frame_byte(input logic [7:0] b, input logic last);
        int      pos;
        int      tcp_start;
        int      rel;
        int      pay_start;
        int      plen;
        int      lim;
        bit      ok;
        t_record rec;
        pos = int'(frame_st.byte_offset);
        if (pos == POS_ETYPE_HI) frame_st.ether_type = {b, 8'h00};
        else if (pos == POS_ETYPE_LO) frame_st.ether_type = frame_st.ether_type | {8'h00, b};
        else if (pos == POS_IHL) frame_st.ip_header_words = b[3:0];
        else if (pos == POS_TOTAL_HI) frame_st.ip_total_length = {b, 8'h00};
        else if (pos == POS_TOTAL_LO)
            frame_st.ip_total_length = frame_st.ip_total_length | {8'h00, b};
        else if (pos == POS_PROTO) frame_st.ip_protocol = b;
        else if (pos >= POS_SRC_ADDR && pos < POS_DST_ADDR)
            frame_st.src_addr = frame_st.src_addr | (32'(b) << (8 * (pos - POS_SRC_ADDR)));
        else if (pos >= POS_DST_ADDR && pos < POS_DST_ADDR + 4)
            frame_st.dst_addr = frame_st.dst_addr | (32'(b) << (8 * (pos - POS_DST_ADDR)));

        if (frame_st.ip_header_words >= MIN_HDR_WORDS) begin
            tcp_start = int'(ETH_HDR_LEN) + 4 * int'(frame_st.ip_header_words);
            if (pos >= tcp_start) begin
                rel = pos - tcp_start;
                if (rel < TCP_DPORT_OFS) frame_st.tcp_sport = {frame_st.tcp_sport[7:0], b};
                else if (rel < TCP_SEQ_OFS) frame_st.tcp_dport = {frame_st.tcp_dport[7:0], b};
                else if (rel < TCP_ACK_OFS)
                    frame_st.seq_number = {frame_st.seq_number[23:0], b};
                else if (rel < TCP_DOFF_OFS)
                    frame_st.ack_number = {frame_st.ack_number[23:0], b};
                else if (rel == TCP_DOFF_OFS) frame_st.tcp_header_words = b[7:4];
            end
            if (frame_st.tcp_header_words >= MIN_HDR_WORDS) begin
                pay_start = tcp_start + 4 * int'(frame_st.tcp_header_words);
                if (pos >= pay_start) begin
                    rel  = pos - pay_start;
                    plen = payload_len_now();
                    lim  = (cfg_shadow.capture_limit > CAP_MAX) ? int'(CAP_MAX)
                                                                : int'(cfg_shadow.capture_limit);
                    if (rel == TYPE_BYTE_OFS) frame_st.type_byte = b;
                    // Payload words go out before the frame is known to fit.
                    if (header_checks_pass() && plen > 0 && rel < plen &&
                        int'(frame_st.captured_count) < lim) begin
                        rec = '0;
                        rec.record_kind  = KIND_PAYLOAD;
                        rec.payload_byte = b;
                        expected_records.push_back(rec);
                        frame_st.captured_count = frame_st.captured_count + 9'd1;
                    end
                end
            end
        end

        if (last) begin
            plen = payload_len_now();
            ok   = header_checks_pass();
            if (ok) begin
                pay_start = int'(ETH_HDR_LEN) + 4 * int'(frame_st.ip_header_words)
                            + 4 * int'(frame_st.tcp_header_words);
                ok = (pay_start + plen <= pos + 1);
            end
            rec = '0;
            rec.record_kind    = KIND_SUMMARY;
            rec.accepted       = ok;
            rec.src_address    = frame_st.src_addr;
            rec.dst_address    = frame_st.dst_addr;
            rec.tcp_sport      = frame_st.tcp_sport;
            rec.tcp_dport      = frame_st.tcp_dport;
            rec.seq_number     = frame_st.seq_number;
            rec.ack_number     = frame_st.ack_number;
            rec.message_type   = frame_st.type_byte;
            rec.payload_length = (plen > 0) ? 16'(plen) : 16'd0;
            rec.end_of_frame   = 1'b1;
            expected_records.push_back(rec);
            frame_st = '0;
        end else if (frame_st.byte_offset < POS_SATURATED) begin
            frame_st.byte_offset = frame_st.byte_offset + 16'd1;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_record got;
        t_record want;
        string   diffs;
        if (!i_rst_n) begin
            cfg_shadow.port_a        = PORT_A_RESET;
            cfg_shadow.port_b        = PORT_B_RESET;
            cfg_shadow.port_c        = PORT_C_RESET;
            cfg_shadow.capture_limit = CAP_LIMIT_RESET;
            frame_st                 = '0;
            expected_records.delete();
            fail_count      = 0;
            records_checked = 0;
            frames_accepted = 0;
        end else begin
            // Output first: a word taken at this edge cannot belong to an input taken now.
            if (i_m_tvalid && i_m_tready) begin
                got.record_kind    = i_m_tuser;
                got.payload_byte   = i_m_tdata[7:0];
                got.accepted       = i_m_tdata[8];
                got.src_address    = i_m_tdata[40:9];
                got.dst_address    = i_m_tdata[72:41];
                got.tcp_sport      = i_m_tdata[88:73];
                got.tcp_dport      = i_m_tdata[104:89];
                got.seq_number     = i_m_tdata[136:105];
                got.ack_number     = i_m_tdata[168:137];
                got.message_type   = i_m_tdata[176:169];
                got.payload_length = i_m_tdata[192:177];
                got.end_of_frame   = i_m_tlast;
                if (expected_records.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("[%0t] unexpected record: %s", $realtime, format_record(got));
                    fail_count++;
                end else begin
                    want  = expected_records.pop_front();
                    diffs = differing_fields(want, got);
                    if (i_m_tdata[199:193] != '0) diffs = {diffs, " padding"};
                    if (diffs != "") begin
                        if (fail_count < MAX_REPORTS) begin
                            $display("[%0t] record %0d mismatch in:%s", $realtime,
                                     records_checked, diffs);
                            $display("    expected %s", format_record(want));
                            $display("    actual   %s", format_record(got));
                        end
                        fail_count++;
                    end
                    records_checked++;
                    if (want.record_kind == KIND_SUMMARY && want.accepted) frames_accepted++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_PORT_A:    cfg_shadow.port_a        = i_cfg_data;
                    CFG_PORT_B:    cfg_shadow.port_b        = i_cfg_data;
                    CFG_PORT_C:    cfg_shadow.port_c        = i_cfg_data;
                    CFG_CAP_LIMIT: cfg_shadow.capture_limit = i_cfg_data[8:0];
                    default:       ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) parse_frame_byte(i_s_tdata, i_s_tlast);
        end
        o_pending <= expected_records.size();
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Top of the TCP port filter testbench: clock, reset, frame stimulus, output stalls and verdict.
// Depends on tpf_pkg, the block tcp_port_filter_payload_capture and tpf_record_checker.
module testbench;
    import tpf_pkg::*;

    // Slowest correct run: about 2.5k frame bytes, each causing up to two records that may each
    // wait out the longest output stall, plus the longest sender gap before the byte. The limit
    // covers that worst case with the drains several times over.
    localparam int LIMIT_CYCLES    = 400_000;
    // Records pass through the result queue after the byte is taken; this margin covers the queue.
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASE_BYTES     = 100;
    localparam int RANDOM_PHASES   = 4;

    logic         i_clk;
    logic         i_rst_n     = 1'b0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata   = 8'h00;
    logic         i_s_tlast   = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [199:0] o_m_tdata;
    logic         o_m_tuser;
    logic         o_m_tlast;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index = 2'd0;
    logic [15:0]  i_cfg_data  = 16'd0;

    int fail_count;
    int pending_records;
    int records_checked;
    int frames_accepted;

    // Stimulus bookkeeping. The selecting ports are mirrored so that random frames can hit them.
    bit          idle_enable = 1'b1;
    logic [15:0] sel_ports [3];
    int          frames_sent;
    int          bytes_sent;
    int          settings_applied;
    int          cycle_count;
    int          ready_hold;

    tcp_port_filter_payload_capture i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tpf_record_checker u_record_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_tvalid        (i_s_tvalid),
        .i_s_tready        (o_s_tready),
        .i_s_tdata         (i_s_tdata),
        .i_s_tlast         (i_s_tlast),
        .i_m_tvalid        (o_m_tvalid),
        .i_m_tready        (i_m_tready),
        .i_m_tdata         (o_m_tdata),
        .i_m_tuser         (o_m_tuser),
        .i_m_tlast         (o_m_tlast),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_pending         (pending_records),
        .o_records_checked (records_checked),
        .o_frames_accepted (frames_accepted)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Output side: ready runs broken by stall bursts, both of random length.
    // With idling off the receiver simply stays ready.
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold--;
        end else if (!idle_enable) begin
            i_m_tready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            i_m_tready <= 1'b0;
            ready_hold = $urandom_range(0, 5);
        end else begin
            i_m_tready <= 1'b1;
            ready_hold = $urandom_range(0, 15);
        end
    end

    // Watchdog: a hung handshake or a lost record ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Offers one frame byte and holds it until the block takes it. A gap burst may come first.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_frame(ref logic [7:0] frame_bytes [$]);
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
        bytes_sent += frame_bytes.size();
    endtask

    // Builds an Ethernet/IPv4/TCP frame. Header lengths below five words still lay down a
    // 20-byte header so the frame has a plausible shape. len_skew shifts the IP total length
    // away from the real sizes; a positive tail appends padding, a negative one cuts the frame.
    task automatic send_tcp_frame(input logic [15:0] etype, input logic [7:0] proto,
                                  input logic [3:0] ihl, input logic [3:0] doff,
                                  input logic [15:0] sport, input logic [15:0] dport,
                                  input int pay_len, input int len_skew, input int tail);
        logic [7:0] frame_bytes [$];
        int         ip_len;
        int         tcp_len;
        int         total;
        int         keep;
        ip_len  = (ihl >= MIN_HDR_WORDS) ? 4 * int'(ihl) : 20;
        tcp_len = (doff >= MIN_HDR_WORDS) ? 4 * int'(doff) : 20;
        total   = 4 * int'(ihl) + 4 * int'(doff) + pay_len + len_skew;
        if (total < 0) total = 0;
        if (total > 65535) total = 65535;
        repeat (12) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(etype[15:8]);
        frame_bytes.push_back(etype[7:0]);
        frame_bytes.push_back({4'h4, ihl});
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(8'(total >> 8));
        frame_bytes.push_back(8'(total));
        // The protocol sits nine bytes into the IP header; addresses stay random.
        for (int i = 4; i < ip_len; i++)
            frame_bytes.push_back((i == 9) ? proto : 8'($urandom));
        frame_bytes.push_back(sport[15:8]);
        frame_bytes.push_back(sport[7:0]);
        frame_bytes.push_back(dport[15:8]);
        frame_bytes.push_back(dport[7:0]);
        repeat (8) frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back({doff, 4'($urandom)});
        for (int i = 13; i < tcp_len; i++) frame_bytes.push_back(8'($urandom));
        repeat (pay_len) frame_bytes.push_back(8'($urandom));
        if (tail > 0) repeat (tail) frame_bytes.push_back(8'($urandom));
        if (tail < 0) begin
            keep = frame_bytes.size() + tail;
            if (keep < 1) keep = 1;
            while (frame_bytes.size() > keep) void'(frame_bytes.pop_back());
        end
        send_frame(frame_bytes);
    endtask

    // A frame of arbitrary bytes; a fill of -1 means random content.
    task automatic send_raw_frame(input int len, input int fill);
        logic [7:0] frame_bytes [$];
        repeat (len) frame_bytes.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        send_frame(frame_bytes);
    endtask

    // Stops sending and waits until every predicted record has come out, then lets the block
    // settle, since a byte may cause no record at all.
    task automatic wait_for_drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_records != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input t_cfg_index idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Registers are only written with the block idle; all four are written every time.
    task automatic apply_config(input logic [15:0] pa, input logic [15:0] pb,
                                input logic [15:0] pc, input logic [15:0] cap);
        wait_for_drain();
        write_register(CFG_PORT_A, pa);
        write_register(CFG_PORT_B, pb);
        write_register(CFG_PORT_C, pc);
        write_register(CFG_CAP_LIMIT, cap);
        i_cfg_valid <= 1'b0;
        sel_ports[0] = pa;
        sel_ports[1] = pb;
        sel_ports[2] = pc;
        settings_applied++;
    endtask

    task automatic randomize_config();
        logic [15:0] pa;
        logic [15:0] pb;
        logic [15:0] pc;
        logic [15:0] cap;
        pa = 16'($urandom);
        pb = 16'($urandom);
        pc = 16'($urandom);
        case ($urandom_range(0, 5))
            0:       cap = 16'd0;
            1:       cap = 16'($urandom_range(1, 6));
            2:       cap = 16'($urandom_range(398, 400));
            3:       cap = 16'hFFFF;
            default: cap = 16'($urandom_range(0, 30));
        endcase
        if ($urandom_range(0, 3) == 0) begin
            pa = PORT_A_RESET;
            pb = PORT_B_RESET;
            pc = PORT_C_RESET;
        end
        if ($urandom_range(0, 5) == 0) pb = 16'hFFFF;
        if ($urandom_range(0, 5) == 0) pc = 16'h0000;
        apply_config(pa, pb, pc, cap);
    endtask

    // Most random frames are well formed with a selecting port so that the payload path is
    // exercised; a quarter break one rule, and the rest are plain noise.
    task automatic send_random_frame();
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [3:0]  ihl;
        logic [3:0]  doff;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] hit;
        int          pay_len;
        int          len_skew;
        int          tail;
        int          pick;
        pick     = $urandom_range(0, 99);
        etype    = ETHERTYPE_IPV4;
        proto    = PROTO_TCP;
        ihl      = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : MIN_HDR_WORDS;
        doff     = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 15)) : MIN_HDR_WORDS;
        pay_len  = $urandom_range(4, 24);
        len_skew = 0;
        tail     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        hit      = sel_ports[$urandom_range(0, 2)];
        sport    = 16'($urandom);
        dport    = 16'($urandom);
        if ($urandom_range(0, 1) == 0) sport = hit;
        else dport = hit;
        if (pick >= 90) begin
            send_raw_frame($urandom_range(1, 60), -1);
        end else begin
            if (pick >= 65) begin
                case ($urandom_range(0, 7))
                    0: etype   = 16'($urandom);
                    1: proto   = 8'($urandom);
                    2: ihl     = 4'($urandom_range(0, 4));
                    3: doff    = 4'($urandom_range(0, 4));
                    4: begin
                        sport = 16'($urandom);
                        dport = 16'($urandom);
                    end
                    5: pay_len  = $urandom_range(0, 3);
                    6: len_skew = -$urandom_range(1, 60);
                    default: tail = -$urandom_range(1, 50);
                endcase
            end
            send_tcp_frame(etype, proto, ihl, doff, sport, dport, pay_len, len_skew, tail);
        end
    endtask

    initial begin
        int phase_start;
        frames_sent      = 0;
        bytes_sent       = 0;
        settings_applied = 0;
        ready_hold       = 0;
        sel_ports[0]     = PORT_A_RESET;
        sel_ports[1]     = PORT_B_RESET;
        sel_ports[2]     = PORT_C_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames under the reset settings. The first one ends on its last payload
        // byte, so that byte and the summary fall on the same word.
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, PORT_A_RESET, 16'd1234, 8, 0, 0);
        // Largest header lengths, shortest payload that passes, match on the destination port.
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 15, 15, 16'hFFFF, PORT_C_RESET, 4, 0, 3);
        send_tcp_frame(16'h86DD, PROTO_TCP, 5, 5, PORT_B_RESET, 16'd80, 8, 0, 0);
        send_tcp_frame(ETHERTYPE_IPV4, 8'd17, 5, 5, PORT_B_RESET, 16'd80, 8, 0, 0);
        // IP or TCP header lengths below five words stop the parse there.
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 4, 5, PORT_A_RESET, 16'd80, 8, 0, 0);
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 0, 5, PORT_A_RESET, 16'd80, 8, 0, 0);
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 4, PORT_A_RESET, 16'd80, 8, 0, 0);
        // No selecting port on either side.
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, 16'd80, 16'd443, 8, 0, 0);
        // Payloads of three bytes and of none are rejected.
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, PORT_A_RESET, 16'd80, 3, 0, 0);
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, PORT_A_RESET, 16'd80, 0, 0, 5);
        // Total length below the headers: the payload length reads as zero.
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, PORT_A_RESET, 16'd80, 0, -40, 2);
        // Payload one byte longer than the frame: bytes go out, the summary rejects.
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 6, 5, PORT_A_RESET, 16'd80, 9, 0, -1);
        // Frame cut inside the IP header: later fields stay zero.
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, PORT_A_RESET, 16'd80, 8, 0, -40);
        send_raw_frame(1, 8'hFF);
        send_raw_frame(20, 8'h00);
        send_raw_frame(60, 8'hFF);

        // Port extremes and a capture limit of zero: accepted, but no payload words.
        apply_config(16'h0000, 16'hFFFF, 16'd1234, 16'd0);
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, 16'h0000, 16'd80, 6, 0, 0);
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, 16'd80, 16'hFFFF, 6, 0, 0);
        apply_config(16'h0000, 16'hFFFF, 16'd1234, 16'd3);
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, 16'd1234, 16'd80, 10, 0, 0);

        // Limit above the buffer: it clamps.
        apply_config(PORT_A_RESET, PORT_B_RESET, PORT_C_RESET, 16'hFFFF);
        send_tcp_frame(ETHERTYPE_IPV4, PROTO_TCP, 5, 5, PORT_B_RESET, 16'd80, 400, 0, 0);

        // Random phases, each under its own settings. Idling alternates and the last phase
        // runs without any. Now and then the sender waits for the output to drain.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            randomize_config();
            idle_enable <= (phase % 2 == 0);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_random_frame();
                if ($urandom_range(0, 9) == 0) wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d frames (%0d bytes) under %0d register settings plus the reset one.",
                 frames_sent, bytes_sent, settings_applied);
        $display("Checked %0d output records; %0d frames passed the filter.",
                 records_checked, frames_accepted);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
